// ===== hdl/mlr_pkg.sv =====
// ----------------------------------------------------------------------------
// Midpoint line rasterizer package
// Command kinds and stepping cases shared by the rasterizer files.
// ----------------------------------------------------------------------------
package mlr_pkg;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_STEP  = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    CASE_X_RISE = 2'd0,
    CASE_Y_RISE = 2'd1,
    CASE_X_FALL = 2'd2,
    CASE_Y_FALL = 2'd3
  } octant_t;

endpackage

// ===== hdl/mlr_if.sv =====
// ----------------------------------------------------------------------------
// Midpoint line rasterizer channels
// Command channel (segment start or step request) and pixel channel.
// ----------------------------------------------------------------------------
interface mlr_cmd_if #(parameter int COORD_BITS = 12);
  logic                  valid;
  logic                  ready;
  mlr_pkg::kind_t        kind;
  logic [COORD_BITS-1:0] x_start;
  logic [COORD_BITS-1:0] y_start;
  logic [COORD_BITS-1:0] x_end;
  logic [COORD_BITS-1:0] y_end;

  modport source (output valid, kind, x_start, y_start, x_end, y_end, input ready);
  modport sink   (input valid, kind, x_start, y_start, x_end, y_end, output ready);
endinterface

interface mlr_pix_if #(parameter int COORD_BITS = 12);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic                  last_pixel;

  modport source (output valid, pixel_x, pixel_y, last_pixel, input ready);
  modport sink   (input valid, pixel_x, pixel_y, last_pixel, output ready);
endinterface

// ===== hdl/midpoint_line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// Midpoint line rasterizer
// A pixel reaches the output register in the cycle after its word is
// accepted. Throughput: one word per cycle unless the pixel output stalls,
// set by the single register stage of decision value and current pixel.
// Reset clears the stepping state to idle and empties the output register.
// ----------------------------------------------------------------------------
module midpoint_line_rasterizer #(
  parameter int COORD_BITS = 12
) (
  input  logic      clk,
  input  logic      rst,
  mlr_cmd_if.sink   cmd,
  mlr_pix_if.source pix
);

  localparam int W  = COORD_BITS;
  localparam int DW = COORD_BITS + 3;

  logic [W-1:0]          cur_x, cur_x_next;
  logic [W-1:0]          cur_y, cur_y_next;
  logic [W-1:0]          major_end, major_end_next;
  logic signed [DW-1:0]  decision, decision_next;
  logic signed [DW-1:0]  incr_straight, incr_straight_next;
  logic signed [DW-1:0]  incr_diagonal, incr_diagonal_next;
  mlr_pkg::octant_t      octant_case, octant_case_next;
  logic                  active, active_next;

  logic                  out_valid;
  logic [W-1:0]          out_x, out_y;
  logic                  out_last;
  logic                  emit, emit_last;

  logic                  accept;
  logic signed [W:0]     dx, dy;
  logic [W-1:0]          adx, ady;
  logic                  swap, x_major, falling;
  logic [W-1:0]          big, small_len;
  logic [W-1:0]          px, py;
  logic                  diag;
  logic [W-1:0]          major_now;

  assign cmd.ready = !out_valid || pix.ready;
  assign accept    = cmd.valid && cmd.ready;

  always_comb begin
    dx      = $signed({1'b0, cmd.x_end}) - $signed({1'b0, cmd.x_start});
    dy      = $signed({1'b0, cmd.y_end}) - $signed({1'b0, cmd.y_start});
    adx     = dx[W] ? W'(-dx) : dx[W-1:0];
    ady     = dy[W] ? W'(-dy) : dy[W-1:0];
    swap    = dx[W];
    falling = (!dy[W] && (dy != '0)) ^ !dx[W];
    if (!dy[W] && (dy != '0) && !dx[W]) begin
      x_major = (ady <= adx);
    end else begin
      x_major = (adx > ady);
    end
    big       = x_major ? adx : ady;
    small_len = x_major ? ady : adx;
    px        = swap ? cmd.x_end : cmd.x_start;
    py        = swap ? cmd.y_end : cmd.y_start;

    diag      = decision[DW-1] || (decision == '0);
    major_now = '0;

    cur_x_next         = cur_x;
    cur_y_next         = cur_y;
    major_end_next     = major_end;
    decision_next      = decision;
    incr_straight_next = incr_straight;
    incr_diagonal_next = incr_diagonal;
    octant_case_next   = octant_case;
    active_next        = active;
    emit               = 1'b0;
    emit_last          = 1'b0;

    if (cmd.kind == mlr_pkg::KIND_START) begin
      octant_case_next   = mlr_pkg::octant_t'({falling, !x_major});
      cur_x_next         = px;
      cur_y_next         = py;
      major_end_next     = x_major ? (swap ? cmd.x_start : cmd.x_end)
                                   : (swap ? cmd.y_start : cmd.y_end);
      decision_next      = $signed({3'b000, big}) - $signed({2'b00, small_len, 1'b0});
      incr_straight_next = -$signed({2'b00, small_len, 1'b0});
      incr_diagonal_next = $signed({2'b00, W'(big - small_len), 1'b0});
      active_next        = (big != '0);
      emit               = 1'b1;
      emit_last          = (big == '0);
    end else if (active) begin
      decision_next = decision + (diag ? incr_diagonal : incr_straight);
      case (octant_case)
        mlr_pkg::CASE_X_RISE: begin
          cur_x_next = cur_x + 1'b1;
          cur_y_next = diag ? cur_y + 1'b1 : cur_y;
          major_now  = cur_x_next;
        end
        mlr_pkg::CASE_Y_RISE: begin
          cur_y_next = cur_y + 1'b1;
          cur_x_next = diag ? cur_x + 1'b1 : cur_x;
          major_now  = cur_y_next;
        end
        mlr_pkg::CASE_X_FALL: begin
          cur_x_next = cur_x + 1'b1;
          cur_y_next = diag ? cur_y - 1'b1 : cur_y;
          major_now  = cur_x_next;
        end
        default: begin
          cur_y_next = cur_y - 1'b1;
          cur_x_next = diag ? cur_x + 1'b1 : cur_x;
          major_now  = cur_y_next;
        end
      endcase
      active_next = (major_now != major_end);
      emit        = 1'b1;
      emit_last   = (major_now == major_end);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x         <= '0;
      cur_y         <= '0;
      major_end     <= '0;
      decision      <= '0;
      incr_straight <= '0;
      incr_diagonal <= '0;
      octant_case   <= mlr_pkg::CASE_X_RISE;
      active        <= 1'b0;
    end else if (accept) begin
      cur_x         <= cur_x_next;
      cur_y         <= cur_y_next;
      major_end     <= major_end_next;
      decision      <= decision_next;
      incr_straight <= incr_straight_next;
      incr_diagonal <= incr_diagonal_next;
      octant_case   <= octant_case_next;
      active        <= active_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= emit;
    end else if (pix.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_x    <= cur_x_next;
      out_y    <= cur_y_next;
      out_last <= emit_last;
    end
  end

  assign pix.valid      = out_valid;
  assign pix.pixel_x    = out_x;
  assign pix.pixel_y    = out_y;
  assign pix.last_pixel = out_last;

  a_idle_step_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.kind == mlr_pkg::KIND_STEP && !active) |=> !pix.valid)
    else $error("step while idle produced a pixel");

  a_start_emits: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.kind == mlr_pkg::KIND_START) |=> pix.valid)
    else $error("segment start produced no pixel");

  a_point_segment: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.kind == mlr_pkg::KIND_START && cmd.x_start == cmd.x_end
     && cmd.y_start == cmd.y_end) |=> (pix.last_pixel && !active))
    else $error("single-point segment not flagged as last");

  a_last_goes_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.kind == mlr_pkg::KIND_STEP && active && emit_last) |=> !active)
    else $error("block stayed active after the last pixel");

endmodule
